@@ rtl/gblur_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 3x3 Gaussian blur block.
package gblur_pkg;

    localparam int LINE_LENGTH_DEF = 1920;

    localparam int PIX_W      = 32;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd1920;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 12'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] word_t;

    typedef struct packed {
        logic signed [31:0] pixel_data;
        logic [3:0]         keep_bits;
        logic [3:0]         strobe_bits;
        logic [2:0]         user_bits;
        logic               last_flag;
        logic [4:0]         stream_id;
        logic [5:0]         dest_bits;
    } pixel_in_t;

    typedef struct packed {
        logic signed [31:0] out_data;
        logic [3:0]         out_keep;
        logic [3:0]         out_strobe;
        logic [2:0]         out_user;
        logic               out_last;
        logic [4:0]         out_id;
        logic [5:0]         out_dest;
    } pixel_out_t;

    // 1-2-1 weighting, wraps mod 2^32
    function automatic word_t weigh_121(input word_t a, input word_t b, input word_t c);
        weigh_121 = a + {b[PIX_W-2:0], 1'b0} + c;
    endfunction

endpackage

@@ rtl/gaussian_blur_3x3_line_buffered.sv @@
// Top level of the streaming 3x3 Gaussian blur with two line stores.
//
// Use: pixels arrive in raster order on the s_ channel (valid/ready), one
// request per pixel, and each yields exactly one filtered pixel on the m_
// channel, in order, with all sideband fields copied through.
// The two previous rows live in one memory, one entry per column holding
// {older row, recent row}; each pixel reads its column, then writes it back
// shifted down. The 3x3 window is kept as three column sums (1-2-1).
// Path from input accept to m_valid: memory read on the accept edge, then
// column sum, then window sum into the output register. Throughput: 1 pixel
// per cycle sustained while m_ready is high; the single-port-each-way line
// memory does one read and one write per cycle. A read that hits the column
// being written in the same cycle (one-column rows) takes the forwarded word.
// Stalls: while m_ready is low, the result holds in the output register and
// the two inner stages keep filling, so up to three requests are in flight
// before s_ready drops. Reset: line stores, window and counters read as zero;
// cols=1920, rows=1080. The stores need no clearing pass: a fill mark tracks
// written columns. The user writes config (cfg_we/cfg_index/cfg_wdata) only
// while the block is idle; the block itself does not enforce this.
module gaussian_blur_3x3_line_buffered #(
    parameter int LINE_LENGTH = gblur_pkg::LINE_LENGTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gblur_pkg::pixel_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gblur_pkg::pixel_out_t             m_data,
    input  logic                              cfg_we,
    input  gblur_pkg::cfg_reg_t               cfg_index,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import gblur_pkg::*;

    localparam int AW = $clog2(LINE_LENGTH);
    localparam int MW = 2 * PIX_W;

    // handshake / pipeline advance
    logic s_acc;
    logic s1_adv, s2_adv, out_free, s1_free, s2_free;

    // stage 1: line memory read data available
    logic              s1_valid_reg;
    pixel_in_t         s1_data_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_seen_reg;
    logic              s1_fwd_reg;
    logic [MW-1:0]     s1_fwd_word_reg;

    // stage 2: column sum of the new right column
    logic              s2_valid_reg;
    pixel_in_t         s2_data_reg;
    word_t             s2_cs_reg;

    // window column sums: middle column and right column of the last window
    word_t             win_mid_reg;
    word_t             win_right_reg;

    // output register
    logic              m_valid_reg;
    pixel_out_t        m_data_reg;

    logic [AW-1:0]     rd_addr;
    logic              rd_seen;
    logic [MW-1:0]     ram_rdata;
    logic [MW-1:0]     line_word;
    logic [MW-1:0]     ram_wdata;
    word_t             pix_w;
    word_t             cs_new;
    word_t             win_sum;
    logic              fwd_hit;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign s_ready  = s1_free;
    assign s_acc    = s_valid && s_ready;

    gblur_raster #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (s_acc),
        .rd_addr   (rd_addr),
        .rd_seen   (rd_seen)
    );

    gblur_line_ram #(
        .DEPTH (LINE_LENGTH),
        .WIDTH (MW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (s_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        // entry = {older row, recent row}; unwritten columns read as zero
        if (s1_fwd_reg) begin
            line_word = s1_fwd_word_reg;
        end else if (s1_seen_reg) begin
            line_word = ram_rdata;
        end else begin
            line_word = '0;
        end
        pix_w     = word_t'(s1_data_reg.pixel_data);
        ram_wdata = {line_word[PIX_W-1:0], pix_w};
        cs_new    = weigh_121(line_word[MW-1:PIX_W], line_word[PIX_W-1:0], pix_w);
        // window after shift: old middle, old right, new column
        win_sum   = weigh_121(win_mid_reg, win_right_reg, s2_cs_reg);
        // read at the same edge as the write to that column sees old data
        fwd_hit   = s1_adv && (rd_addr == s1_addr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            win_mid_reg   <= '0;
            win_right_reg <= '0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (s2_adv) begin
                win_mid_reg   <= win_right_reg;
                win_right_reg <= s2_cs_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_data_reg     <= s_data;
            s1_addr_reg     <= rd_addr;
            s1_seen_reg     <= rd_seen;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_word_reg <= ram_wdata;
        end
        if (s1_adv) begin
            s2_data_reg <= s1_data_reg;
            s2_cs_reg   <= cs_new;
        end
        if (s2_adv) begin
            m_data_reg.out_data   <= $signed(win_sum) >>> 4;
            m_data_reg.out_keep   <= s2_data_reg.keep_bits;
            m_data_reg.out_strobe <= s2_data_reg.strobe_bits;
            m_data_reg.out_user   <= s2_data_reg.user_bits;
            m_data_reg.out_last   <= s2_data_reg.last_flag;
            m_data_reg.out_id     <= s2_data_reg.stream_id;
            m_data_reg.out_dest   <= s2_data_reg.dest_bits;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/gblur_line_ram.sv @@
// Simple dual-port line store: one write port, one registered read port.
module gblur_line_ram #(
    parameter int DEPTH = 1920,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gblur_raster.sv @@
// Config registers, raster column/row counters and line store fill tracking.
module gblur_raster #(
    parameter int LINE_LENGTH = gblur_pkg::LINE_LENGTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  gblur_pkg::cfg_reg_t                cfg_index,
    input  logic [gblur_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               step,
    output logic [$clog2(LINE_LENGTH)-1:0]     rd_addr,
    output logic                               rd_seen
);
    import gblur_pkg::*;

    localparam int AW = $clog2(LINE_LENGTH);
    localparam int NW = $clog2(LINE_LENGTH + 1);
    localparam int LW = (NW > COLS_W) ? NW : COLS_W;

    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [AW-1:0]     col_reg, col_next;
    logic [ROWS_W-1:0] row_reg, row_next;
    logic [NW-1:0]     fill_reg, fill_next;

    logic [LW-1:0]     ncols;
    logic [ROWS_W-1:0] nrows;
    logic [AW-1:0]     col_cur;
    logic [ROWS_W-1:0] row_cur;
    logic [ROWS_W-1:0] row_inc;
    logic [AW:0]       col_inc;
    logic              wrap;

    always_comb begin
        if (cols_reg == '0) begin
            ncols = LW'(1);
        end else if (LW'(cols_reg) > LW'(LINE_LENGTH)) begin
            ncols = LW'(LINE_LENGTH);
        end else begin
            ncols = LW'(cols_reg);
        end
        nrows = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;

        // counters past a lowered limit restart at zero
        col_cur = (LW'(col_reg) >= ncols) ? '0 : col_reg;
        row_cur = (row_reg >= nrows) ? '0 : row_reg;

        col_inc  = {1'b0, col_cur} + (AW+1)'(1);
        wrap     = (LW'(col_inc) >= ncols);
        col_next = wrap ? '0 : col_inc[AW-1:0];
        row_inc  = row_cur + ROWS_W'(1);
        if (wrap) begin
            row_next = (row_inc >= nrows) ? '0 : row_inc;
        end else begin
            row_next = row_cur;
        end

        // columns are written as a growing prefix; beyond it the store reads zero
        fill_next = (NW'(col_inc) > fill_reg) ? NW'(col_inc) : fill_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
            fill_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_COLS: cols_reg <= cfg_wdata[COLS_W-1:0];
                    REG_ROWS: rows_reg <= cfg_wdata[ROWS_W-1:0];
                    default:  cols_reg <= cols_reg;
                endcase
            end
            if (step) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                fill_reg <= fill_next;
            end
        end
    end

    assign rd_addr = col_cur;
    assign rd_seen = (NW'(col_cur) < fill_reg);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the streaming 3x3 Gaussian blur with two line stores.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gblur_pkg::*;

    localparam int LINE_LEN      = LINE_LENGTH_DEF;
    localparam int RANDOM_PIXELS = 1950;
    localparam int HOLD_CYCLES   = 300;     // one long m_ready hold-off
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;       // pipeline is 3 deep

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pixel_out_t            m_data;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_index = REG_COLS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gaussian_blur_3x3_line_buffered #(
        .LINE_LENGTH (LINE_LEN)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Blur predictor state: own copy of the line stores, window, raster
    // counters and the two config registers. Stores, window and counters start
    // at zero, config at its reset values; never cleared between frames.
    // ------------------------------------------------------------------
    word_t              older_row  [LINE_LEN];
    word_t              recent_row [LINE_LEN];
    word_t              blur_win   [9];
    int                 col_pos;
    int                 row_pos;
    logic [COLS_W-1:0]  cols_cfg;
    logic [ROWS_W-1:0]  rows_cfg;

    // Requests waiting to be driven, and filtered pixels still owed by the DUT.
    pixel_in_t          pending_pixels [$];
    pixel_out_t         expected_blur  [$];

    // Handshakes seen at the last rising edge, for the falling-edge processes.
    logic               s_fire = 1'b0;
    logic               m_fire = 1'b0;

    int                 pushed_cnt   = 0;
    int                 accepted_cnt = 0;
    int                 checked_cnt  = 0;
    int                 err_cnt      = 0;
    int                 stall_cycles = 0;   // s_valid high, s_ready low
    int                 setting_cnt  = 0;
    int                 cycle_cnt    = 0;
    logic               hold_req     = 1'b0;

    // Effective limits: zero reads as one, cols capped at the store depth.
    // Column sum runs 1-2-1 down each window column, 1-2-1 across, wrap mod 2^32,
    // then an arithmetic shift right by 4.
    function automatic pixel_out_t blur_pixel(input pixel_in_t px);
        int         ncols;
        int         nrows;
        int         col;
        word_t      top;
        word_t      mid;
        word_t      sum;
        pixel_out_t res;
        ncols = (cols_cfg == 0) ? 1 : ((cols_cfg > LINE_LEN) ? LINE_LEN : int'(cols_cfg));
        nrows = (rows_cfg == 0) ? 1 : int'(rows_cfg);
        // counters left beyond a lowered limit restart at zero
        if (col_pos >= ncols) col_pos = 0;
        if (row_pos >= nrows) row_pos = 0;
        col = col_pos;
        for (int k = 0; k < 3; k++) begin
            blur_win[k*3]   = blur_win[k*3+1];
            blur_win[k*3+1] = blur_win[k*3+2];
        end
        top = older_row[col];
        mid = recent_row[col];
        older_row[col]  = mid;
        recent_row[col] = px.pixel_data;
        blur_win[2] = top;
        blur_win[5] = mid;
        blur_win[8] = px.pixel_data;
        sum = blur_win[0] + (blur_win[1] << 1) + blur_win[2]
            + (blur_win[3] << 1) + (blur_win[4] << 2) + (blur_win[5] << 1)
            + blur_win[6] + (blur_win[7] << 1) + blur_win[8];
        res.out_data   = $signed(sum) >>> 4;
        res.out_keep   = px.keep_bits;
        res.out_strobe = px.strobe_bits;
        res.out_user   = px.user_bits;
        res.out_last   = px.last_flag;
        res.out_id     = px.stream_id;
        res.out_dest   = px.dest_bits;
        col_pos = col + 1;
        if (col_pos >= ncols) begin
            col_pos = 0;
            row_pos = row_pos + 1;
            if (row_pos >= nrows) row_pos = 0;
        end
        return res;
    endfunction

    // Wait count for one request or result: 0..10, with occasional runs of zero waits.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. A filtered pixel is
    // checked against the oldest prediction; an accepted request is run
    // through the predictor. No result can leave in the cycle its request
    // enters, so checking before predicting is safe.
    // ------------------------------------------------------------------
    task automatic check_blur(input pixel_out_t got);
        pixel_out_t want;
        if (expected_blur.size() == 0) begin
            $error("unexpected filtered pixel: out_data %0d", got.out_data);
            err_cnt++;
            return;
        end
        want = expected_blur.pop_front();
        checked_cnt++;
        if (got.out_data !== want.out_data) begin
            $error("out_data: expected %0d, got %0d", want.out_data, got.out_data);
            err_cnt++;
        end
        if (got.out_keep !== want.out_keep) begin
            $error("out_keep: expected %0h, got %0h", want.out_keep, got.out_keep);
            err_cnt++;
        end
        if (got.out_strobe !== want.out_strobe) begin
            $error("out_strobe: expected %0h, got %0h", want.out_strobe, got.out_strobe);
            err_cnt++;
        end
        if (got.out_user !== want.out_user) begin
            $error("out_user: expected %0h, got %0h", want.out_user, got.out_user);
            err_cnt++;
        end
        if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
            err_cnt++;
        end
        if (got.out_id !== want.out_id) begin
            $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
            err_cnt++;
        end
        if (got.out_dest !== want.out_dest) begin
            $error("out_dest: expected %0h, got %0h", want.out_dest, got.out_dest);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire <= 1'b0;
            m_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            m_fire <= m_valid && m_ready;
            if (m_valid && m_ready) check_blur(m_data);
            if (s_valid && s_ready) begin
                expected_blur.push_back(blur_pixel(s_data));
                accepted_cnt++;
            end
            if (s_valid && !s_ready) stall_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: falling edge. Holds a request until the monitor saw it taken,
    // then waits its drawn gap before offering the next. s_valid gets a
    // single assignment per edge, so back-to-back requests keep it high.
    // ------------------------------------------------------------------
    int src_gap  = 0;
    int src_calm = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap  = 0;
        end else if (!(s_valid && !s_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                s_data  <= pending_pixels.pop_front();
                s_valid <= 1'b1;
                src_gap  = draw_wait(src_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: falling edge. After each taken result it stalls for a drawn
    // count; once, on request, it holds off for a long stretch so the line
    // pipeline fills and s_ready has to drop.
    // ------------------------------------------------------------------
    int   sink_stall = 0;
    int   sink_calm  = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_fire) sink_stall = draw_wait(sink_calm);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Idle means every pushed request taken and every filtered pixel back;
    // each request yields one result, so nothing hides in the pipeline.
    task automatic wait_drained();
        do @(negedge aclk);
        while (accepted_cnt != pushed_cnt || expected_blur.size() != 0);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_COLS) cols_cfg = val[COLS_W-1:0];
        else                 rows_cfg = val[ROWS_W-1:0];
    endtask

    // Drain, program cols and rows, then line up at a rising edge so the
    // queue fills away from the driver's falling edge.
    task automatic new_setting(input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] r);
        wait_drained();
        write_cfg(REG_COLS, c);
        write_cfg(REG_ROWS, r);
        setting_cnt++;
        @(posedge aclk);
    endtask

    task automatic push_pixel(input pixel_in_t px);
        pending_pixels.push_back(px);
        pushed_cnt++;
    endtask

    function automatic pixel_in_t rand_pixel();
        pixel_in_t px;
        int        kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       px.pixel_data = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2, 3: px.pixel_data = $signed($urandom_range(0, 511)) - 256;
            default: px.pixel_data = $urandom;
        endcase
        px.keep_bits   = 4'($urandom_range(0, 15));
        px.strobe_bits = 4'($urandom_range(0, 15));
        px.user_bits   = 3'($urandom_range(0, 7));
        px.last_flag   = 1'($urandom_range(0, 1));
        px.stream_id   = 5'($urandom_range(0, 31));
        px.dest_bits   = 6'($urandom_range(0, 63));
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    word_t corner_vals [12] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h0000_000F, 32'h0000_0010, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFF0
    };

    initial begin
        pixel_in_t             px;
        int                    rand_left;
        int                    n;
        int                    pick;
        logic [CFG_DATA_W-1:0] c_val;
        logic [CFG_DATA_W-1:0] r_val;

        foreach (older_row[i]) begin
            older_row[i]  = '0;
            recent_row[i] = '0;
        end
        foreach (blur_win[i]) blur_win[i] = '0;
        col_pos  = 0;
        row_pos  = 0;
        cols_cfg = COLS_RESET;
        rows_cfg = ROWS_RESET;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: data extremes at reset geometry, sidebands all ones / all zeros.
        foreach (corner_vals[i]) begin
            px.pixel_data  = corner_vals[i];
            px.keep_bits   = (i % 2) ? 4'hF : 4'h0;
            px.strobe_bits = (i % 2) ? 4'h0 : 4'hF;
            px.user_bits   = (i % 2) ? 3'h7 : 3'h0;
            px.last_flag   = 1'(i % 2);
            px.stream_id   = (i % 2) ? 5'h1F : 5'h00;
            px.dest_bits   = (i % 2) ? 6'h3F : 6'h00;
            push_pixel(px);
        end
        setting_cnt++;

        // Column counter sits at 12: lowering cols to 4 must restart it at 0.
        // Zero rows reads as one row.
        new_setting(12'd4, 12'd0);
        for (int i = 0; i < 5; i++) push_pixel(rand_pixel());

        // Zero cols: one-column rows, every pixel hits the column just written.
        new_setting(12'd0, 12'd4095);
        for (int i = 0; i < 4; i++) push_pixel(rand_pixel());

        // All-ones write: bit 11 drops, 2047 caps at the store depth.
        new_setting(12'hFFF, 12'd1);
        for (int i = 0; i < 4; i++) push_pixel(rand_pixel());

        // Random phases: mostly narrow rows so the vertical taps mix often,
        // plus the extremes of both registers.
        rand_left = RANDOM_PIXELS;
        while (rand_left > 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:          c_val = ($urandom_range(0, 1) != 0) ? 12'd1 : 12'h800;
                1, 2, 3, 4: c_val = {1'($urandom_range(0, 1)), 11'($urandom_range(2, 8))};
                5, 6:       c_val = 12'($urandom_range(9, 64));
                7:          c_val = 12'd1920;
                8:          c_val = 12'($urandom_range(1921, 4095));
                default:    c_val = 12'd3;
            endcase
            case ($urandom_range(0, 5))
                0:       r_val = 12'd0;
                1:       r_val = 12'd4095;
                2, 3:    r_val = 12'($urandom_range(1, 3));
                default: r_val = 12'($urandom_range(1, 4095));
            endcase
            n = (pick == 7 || pick == 8) ? $urandom_range(100, 250) : $urandom_range(30, 150);
            if (n > rand_left) n = rand_left;
            new_setting(c_val, r_val);
            // First random phase: receiver stalls long while requests keep coming.
            if (rand_left == RANDOM_PIXELS) hold_req = 1'b1;
            for (int i = 0; i < n; i++) push_pixel(rand_pixel());
            rand_left -= n;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Blur run: %0d pixels sent, %0d filtered pixels checked, %0d geometries.",
                 accepted_cnt, checked_cnt, setting_cnt);
        $display("Input back-pressure seen for %0d cycles; %0d mismatches.",
                 stall_cycles, err_cnt);
        if (err_cnt == 0 && expected_blur.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ gaussian_blur_3x3_line_buffered.f @@
rtl/gblur_pkg.sv
rtl/gblur_line_ram.sv
rtl/gblur_raster.sv
rtl/gaussian_blur_3x3_line_buffered.sv
tb/testbench.sv
